@@ rtl/bubble_sort_up_down_core_macros.svh @@
// Assertion macros shared by the sorter RTL.
`ifndef BUBBLE_SORT_UP_DOWN_CORE_MACROS_SVH
`define BUBBLE_SORT_UP_DOWN_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BSUD_ASSERT_NOW(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define BSUD_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

@@ rtl/bsud_pkg.sv @@
// Shared types, constants and compare function of the up/down sorter.
`default_nettype none
package bsud_pkg;

   localparam int VALUE_W          = 32;
   localparam int MAX_ELEMENTS_DEF = 64;

   // Control word broadcast from the sequencer to every cell.
   typedef struct packed {
      logic load;       // shift right, new element enters cell 0
      logic sort;       // one compare-exchange phase
      logic drain;      // shift left, cell 0 leaves
      logic phase_odd;  // pairs start at odd cells
      logic descending; // direction sampled when the set closed
   } cell_ctrl_type;

   // True when left must move behind right for the chosen direction.
   function automatic logic out_of_order(input logic signed [VALUE_W-1:0] left,
                                         input logic signed [VALUE_W-1:0] right,
                                         input logic                      down);
      logic res;
      res = down ? (left < right) : (left > right);
      return res;
   endfunction

endpackage
`default_nettype wire

@@ rtl/bsud_cell.sv @@
// One cell of the sorting chain: holds one element and its valid bit.
`default_nettype none
module bsud_cell #(
   parameter bit FIRST_CELL = 1'b0,
   parameter bit ODD_CELL   = 1'b0
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire  bsud_pkg::cell_ctrl_type          ctrl,
   input  wire  signed [bsud_pkg::VALUE_W-1:0]    left_value,
   input  wire                                    left_valid,
   input  wire  signed [bsud_pkg::VALUE_W-1:0]    right_value,
   input  wire                                    right_valid,
   output logic signed [bsud_pkg::VALUE_W-1:0]    value,
   output logic                                   valid
);
   import bsud_pkg::*;

   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic                      valid_ff, valid_in;
   logic                      pair_right;
   logic                      swap_right;
   logic                      swap_left;

   // Valid entries collect at the low end; empty cells trail.
   always_comb begin
      pair_right = (ODD_CELL == ctrl.phase_odd);
      swap_right = (!valid_ff && right_valid) ||
                   (valid_ff && right_valid &&
                    out_of_order(value_ff, right_value, ctrl.descending));
      swap_left  = !FIRST_CELL &&
                   ((!left_valid && valid_ff) ||
                    (left_valid && valid_ff &&
                     out_of_order(left_value, value_ff, ctrl.descending)));
      value_in = value_ff;
      valid_in = valid_ff;
      if (ctrl.load) begin
         value_in = left_value;
         valid_in = left_valid;
      end else if (ctrl.drain) begin
         value_in = right_value;
         valid_in = right_valid;
      end else if (ctrl.sort) begin
         if (pair_right && swap_right) begin
            value_in = right_value;
            valid_in = right_valid;
         end else if (!pair_right && swap_left) begin
            value_in = left_value;
            valid_in = left_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign value = value_ff;
   assign valid = valid_ff;

endmodule
`default_nettype wire

@@ rtl/bubble_sort_up_down_core.sv @@
// Top level of the up/down sorter: cell chain plus load/sort/drain sequencer.
//
// Input stream req_*: one signed 32-bit value per transaction, req_tlast closes
// the set. A set also closes when it reaches MAX_ELEMENTS entries. Values shift
// into a chain of MAX_ELEMENTS cells, one per cycle.
// When the set closes, n odd-even compare-exchange phases run over the chain
// (n = elements in the set), one phase per cycle, with the direction taken from
// the csr register at that moment (csr_data 0 ascending, 1 descending).
// The chain then shifts out one element per cycle into the output register while that register can take it;
// rsp_tlast marks the final element of the run.
// req_tready is low during sorting and draining; the next set may start while
// the final result still waits in the output register.
// When rsp_tready is low while a result waits, the output register and the draining chain hold.
// Reset empties the chain, clears the count and sets ascending order.
// The csr channel is always ready; write it only between transactions.
`default_nettype none
`include "bubble_sort_up_down_core_macros.svh"
module bubble_sort_up_down_core #(
   parameter int MAX_ELEMENTS = bsud_pkg::MAX_ELEMENTS_DEF
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   input  wire  [bsud_pkg::VALUE_W-1:0]         req_tdata,   // [31:0] value
   input  wire                                  req_tlast,   // last
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   output logic [bsud_pkg::VALUE_W-1:0]         rsp_tdata,   // [31:0] sorted_value
   output logic                                 rsp_tlast,   // final_res
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire                                  csr_data     // descending
);
   import bsud_pkg::*;

   localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SORT,
      ST_DRAIN
   } state_type;

   state_type                 state_ff;
   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          phase_cnt_ff;
   logic                      phase_odd_ff;
   logic                      desc_set_ff;
   logic                      descending_ff;
   logic                      rsp_valid_ff;
   logic [VALUE_W-1:0]        rsp_data_ff;
   logic                      rsp_last_ff;

   logic                      req_accept;
   logic                      slot_free;
   logic                      set_closes;
   logic [CNT_W-1:0]          count_inc;
   cell_ctrl_type             ctrl;

   logic signed [VALUE_W-1:0] cell_value [MAX_ELEMENTS];
   logic                      cell_valid [MAX_ELEMENTS];

   assign req_tready = (state_ff == ST_LOAD);
   assign req_accept = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign count_inc  = CNT_W'(count_ff + 1'b1);
   assign set_closes = req_tlast || (count_inc == CNT_W'(MAX_ELEMENTS));
   assign csr_ready  = 1'b1;

   always_comb begin
      ctrl.load       = req_accept;
      ctrl.sort       = (state_ff == ST_SORT);
      ctrl.drain      = (state_ff == ST_DRAIN) && slot_free;
      ctrl.phase_odd  = phase_odd_ff;
      ctrl.descending = desc_set_ff;
   end

   for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
      logic signed [VALUE_W-1:0] left_value;
      logic                      left_valid;
      logic signed [VALUE_W-1:0] right_value;
      logic                      right_valid;

      if (i == 0) begin : g_head
         assign left_value = signed'(req_tdata);
         assign left_valid = 1'b1;
      end else begin : g_mid
         assign left_value = cell_value[i-1];
         assign left_valid = cell_valid[i-1];
      end
      if (i == MAX_ELEMENTS - 1) begin : g_tail
         assign right_value = '0;
         assign right_valid = 1'b0;
      end else begin : g_body
         assign right_value = cell_value[i+1];
         assign right_valid = cell_valid[i+1];
      end

      bsud_cell #(
         .FIRST_CELL (i == 0),
         .ODD_CELL   ((i % 2) == 1)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .left_value  (left_value),
         .left_valid  (left_valid),
         .right_value (right_value),
         .right_valid (right_valid),
         .value       (cell_value[i]),
         .valid       (cell_valid[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         count_ff      <= '0;
         phase_cnt_ff  <= '0;
         phase_odd_ff  <= 1'b0;
         desc_set_ff   <= 1'b0;
         descending_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rsp_last_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            descending_ff <= csr_data;
         end
         // drop the taken result unless a new one advances in the same cycle
         if (rsp_valid_ff && rsp_tready && !ctrl.drain) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_LOAD: begin
               if (req_accept) begin
                  count_ff <= count_inc;
                  if (set_closes) begin
                     state_ff     <= ST_SORT;
                     phase_cnt_ff <= count_inc;
                     phase_odd_ff <= 1'b0;
                     desc_set_ff  <= descending_ff;
                  end
               end
            end
            ST_SORT: begin
               phase_odd_ff <= !phase_odd_ff;
               phase_cnt_ff <= CNT_W'(phase_cnt_ff - 1'b1);
               if (phase_cnt_ff == CNT_W'(1)) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               // advance one element into the output register
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_last_ff  <= (count_ff == CNT_W'(1));
                  count_ff     <= CNT_W'(count_ff - 1'b1);
                  if (count_ff == CNT_W'(1)) begin
                     state_ff <= ST_LOAD;
                  end
               end
            end
            default: begin
               state_ff <= ST_LOAD;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.drain) begin
         rsp_data_ff <= VALUE_W'(cell_value[0]);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   `BSUD_ASSERT_NOW(a_drain_head_valid, clock, reset,
                    ctrl.drain, cell_valid[0], "drain from empty cell")
   `BSUD_ASSERT_NOW(a_count_bound, clock, reset,
                    req_tready, count_ff < CNT_W'(MAX_ELEMENTS), "count overflow")
   `BSUD_ASSERT_NEXT(a_final_ends_set, clock, reset,
                     ctrl.drain && (count_ff == CNT_W'(1)),
                     rsp_tlast && (count_ff == '0), "final result without empty chain")

endmodule
`default_nettype wire
